// ----- sv/sv39ptb_pkg.sv -----
// Package: item types, sizes and codes for the Sv39 page table builder.
`timescale 1ns / 1ps

package sv39ptb_pkg;

  // Store geometry
  localparam int TABLE_PAGES      = 16;
  localparam int IDX_W            = 9;
  localparam int ENTRIES_PER_PAGE = 1 << IDX_W;
  localparam int PAGE_W           = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int ADDR_W           = PAGE_W + IDX_W;
  localparam int STORE_DEPTH      = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int CNT_W            = $clog2(TABLE_PAGES + 1);

  // Entry layout
  localparam int PTE_W      = 64;
  localparam int PPN_W      = 44;
  localparam int PPN_LSB    = 10;
  localparam int PERM_W     = 8;
  localparam int VA_W       = 39;
  localparam int PA_W       = 56;
  localparam int PAGE_SHIFT = 12;
  localparam int VPN2_LSB   = 30;
  localparam int VPN1_LSB   = 21;
  localparam int VPN0_LSB   = 12;

  localparam logic [PPN_W-1:0] BASE_PPN_RESET = PPN_W'(524288);

  // Request kinds
  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [PERM_W-1:0] perm;
  } in_item_t;

  typedef struct packed {
    logic mapped;
    logic status;
  } out_item_t;

endpackage

// ----- sv/sv39_page_table_builder.sv -----
// Top level: Sv39 page table builder and walker over a local table-page store.
`timescale 1ns / 1ps

// Builds and walks a three-level Sv39 page table held in one synchronous
// store of TABLE_PAGES pages of 512 64-bit entries (page 0 is the root).
// One request is worked at a time; each table level is one registered
// read of the store. A map that allocates a table page first clears it
// with a sweep through the store's single write port and then writes
// the link; a map that allocates both levels skips the level-1 read.
// After reset the root page is swept to zero, during which no request is
// accepted; the configuration port is always ready. The result beat
// sits in an output register, so a stalled consumer holds only the next
// result.
module sv39_page_table_builder
  import sv39ptb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // configuration write: table_base_ppn
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PPN_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_L2    = 8'b0000_0100,
    S_L1    = 8'b0000_1000,
    S_L0    = 8'b0001_0000,
    S_LINK  = 8'b0010_0000,
    S_LEAF  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(ENTRIES_PER_PAGE - 1);
  localparam logic [PPN_W-1:0]    PAGES_PPN  = PPN_W'(TABLE_PAGES);
  localparam logic [CNT_W:0]      PAGES_CNT  = (CNT_W + 1)'(TABLE_PAGES);
  localparam logic [PAGE_W-1:0]   ROOT_PAGE  = '0;

  // Table store
  logic [PTE_W-1:0]  mem [STORE_DEPTH];
  logic [PTE_W-1:0]  rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [PTE_W-1:0]  mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Control and request registers
  state_t            state, state_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic              clr_init, clr_init_next;
  logic [CNT_W-1:0]  nfp, nfp_next;
  logic [1:0]        need, need_next;
  logic [PAGE_W-1:0] wpage, wpage_next;
  in_item_t          req, req_next;
  logic [PPN_W-1:0]  base_ppn;
  out_item_t         res, res_next;
  logic              load_out;

  // Request indices
  logic [IDX_W-1:0] i2, i1, i0;
  assign i2 = req.virt_addr[VPN2_LSB +: IDX_W];
  assign i1 = req.virt_addr[VPN1_LSB +: IDX_W];
  assign i0 = req.virt_addr[VPN0_LSB +: IDX_W];

  // Link decode of the entry just read
  logic [PPN_W-1:0]  rel;
  logic              in_store;
  logic [PAGE_W-1:0] rel_page;
  assign rel      = rdata[PPN_LSB +: PPN_W] - base_ppn;
  assign in_store = (rel < PAGES_PPN);
  assign rel_page = rel[PAGE_W-1:0];

  // Free page checks
  logic fits_two, fits_one;
  assign fits_two = ({1'b0, nfp} + (CNT_W + 1)'(2)) <= PAGES_CNT;
  assign fits_one = ({1'b0, nfp} + (CNT_W + 1)'(1)) <= PAGES_CNT;

  // Entries to write
  logic [PPN_W-1:0] link_ppn;
  logic [PTE_W-1:0] link_pte, leaf_pte;
  assign link_ppn = base_ppn + PPN_W'(nfp);
  assign link_pte = {{(PTE_W - PPN_W - PPN_LSB){1'b0}}, link_ppn, {(PPN_LSB - 1){1'b0}}, 1'b1};
  assign leaf_pte = {{(PTE_W - PPN_W - PPN_LSB){1'b0}},
                     req.phys_addr[PAGE_SHIFT +: PPN_W],
                     {(PPN_LSB - PERM_W){1'b0}}, req.perm};

  logic [PAGE_W-1:0] clr_page;
  assign clr_page = clr_init ? ROOT_PAGE : nfp[PAGE_W-1:0];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    clr_init_next = clr_init;
    nfp_next      = nfp;
    need_next     = need;
    wpage_next    = wpage;
    req_next      = req;
    res_next      = res;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {clr_page, cnt};
        cnt_next  = cnt + IDX_W'(1);
        if (cnt == IDX_LAST) begin
          clr_init_next = 1'b0;
          state_next    = clr_init ? S_IDLE : S_LINK;
        end
      end

      S_IDLE: begin
        mem_raddr = {ROOT_PAGE, in_data.virt_addr[VPN2_LSB +: IDX_W]};
        if (in_valid) begin
          req_next   = in_data;
          state_next = S_L2;
        end
      end

      // root entry in rdata
      S_L2: begin
        res_next = '{mapped: 1'b0, status: STATUS_OK};
        if (rdata[0] && in_store) begin
          mem_raddr  = {rel_page, i1};
          wpage_next = rel_page;
          state_next = S_L1;
        end else if (req.kind == KIND_QUERY) begin
          state_next = S_DONE;
        end else if (rdata[0] || !fits_two) begin
          res_next.status = STATUS_FAIL;
          state_next      = S_DONE;
        end else begin
          need_next  = 2'd2;
          wpage_next = ROOT_PAGE;
          cnt_next   = '0;
          state_next = S_CLEAR;
        end
      end

      // level-1 entry in rdata
      S_L1: begin
        if (req.kind == KIND_QUERY) begin
          if (rdata[0] && in_store) begin
            mem_raddr  = {rel_page, i0};
            state_next = S_L0;
          end else begin
            state_next = S_DONE;
          end
        end else if (rdata[0]) begin
          if (in_store) begin
            wpage_next = rel_page;
            state_next = S_LEAF;
          end else begin
            res_next.status = STATUS_FAIL;
            state_next      = S_DONE;
          end
        end else if (!fits_one) begin
          res_next.status = STATUS_FAIL;
          state_next      = S_DONE;
        end else begin
          need_next  = 2'd1;
          cnt_next   = '0;
          state_next = S_CLEAR;
        end
      end

      // leaf entry in rdata
      S_L0: begin
        res_next.mapped = rdata[0];
        state_next      = S_DONE;
      end

      // link the freshly cleared page into its parent
      S_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = {wpage, (need == 2'd2) ? i2 : i1};
        mem_wdata  = link_pte;
        wpage_next = nfp[PAGE_W-1:0];
        nfp_next   = nfp + CNT_W'(1);
        need_next  = need - 2'd1;
        cnt_next   = '0;
        state_next = (need == 2'd1) ? S_LEAF : S_CLEAR;
      end

      S_LEAF: begin
        mem_we          = 1'b1;
        mem_waddr       = {wpage, i0};
        mem_wdata       = leaf_pte;
        res_next.mapped = 1'b1;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_init  <= 1'b1;
      nfp       <= CNT_W'(1);
      need      <= '0;
      base_ppn  <= BASE_PPN_RESET;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      clr_init <= clr_init_next;
      nfp      <= nfp_next;
      need     <= need_next;
      if (cfg_valid && cfg_ready) begin
        base_ppn <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wpage <= wpage_next;
    req   <= req_next;
    res   <= res_next;
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule
